>>> rtl/core/sb32_pkg.sv
// shared types and constants for the strict base32 decoder
package sb32_pkg;

    localparam int COUNT_BITS_DEFAULT = 24;
    localparam int FIELD_BITS         = 24;
    localparam int GROUP_BITS         = 40;
    localparam int SYMBOL_BITS        = 5;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_PTR_BITS     = $clog2(QUEUE_DEPTH);

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] PAD_SYMBOL = 8'h3D;

    typedef struct packed {
        logic       kind;
        logic [7:0] symbol;
    } item_t;

    typedef struct packed {
        logic                  result_kind;
        logic [7:0]            data_byte;
        logic                  final_of_run;
        logic                  decode_error;
        logic [FIELD_BITS-1:0] byte_count;
    } result_t;

    // one unit of work for the output side: a decoded group or an end status
    typedef struct packed {
        logic                  is_status;
        logic                  decode_error;
        logic [FIELD_BITS-1:0] byte_count;
        logic [GROUP_BITS-1:0] group;
        logic [2:0]            nbytes;
    } job_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_wr_t;

endpackage

>>> rtl/core/sb32_front.sv
// input side: symbol classification, group assembly and group checks
module sb32_front #(
    parameter int COUNT_BITS = sb32_pkg::COUNT_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  sb32_pkg::item_t item,
    input  logic            queue_full,
    output logic            push,
    output sb32_pkg::job_t  push_job
);

    localparam int FB   = sb32_pkg::FIELD_BITS;
    localparam int WIDE = (COUNT_BITS > FB) ? COUNT_BITS : FB;
    localparam int KEEP = sb32_pkg::GROUP_BITS - sb32_pkg::SYMBOL_BITS;

    logic [KEEP-1:0]       group_bits_reg, group_bits_next;
    logic [2:0]            group_pos_reg, group_pos_next;
    logic [3:0]            pad_run_reg, pad_run_next;
    logic                  error_reg, error_next;
    logic                  padded_done_reg, padded_done_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;

    logic                  accept;
    logic                  is_pad;
    logic                  sym_ok;
    logic [4:0]            sym_value;
    logic [7:0]            sym_diff;
    logic [3:0]            pad_run_new;
    logic [sb32_pkg::GROUP_BITS-1:0] full_group;
    logic [sb32_pkg::GROUP_BITS-1:0] tail_mask;
    logic [2:0]            nbytes;
    logic                  pad_ok;
    logic                  tail_ok;
    logic [COUNT_BITS:0]   total_sum;
    logic [COUNT_BITS-1:0] total_sat;
    logic [WIDE-1:0]       total_wide;
    logic [FB-1:0]         shown;
    logic                  end_bad;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign is_pad     = (item.symbol == sb32_pkg::PAD_SYMBOL);

    // alphabet lookup
    always_comb
    begin
        sym_ok    = 1'b0;
        sym_diff  = '0;
        if (item.symbol >= 8'h41 && item.symbol <= 8'h5A)
        begin
            sym_ok   = 1'b1;
            sym_diff = item.symbol - 8'h41;
        end
        else if (item.symbol >= 8'h32 && item.symbol <= 8'h37)
        begin
            sym_ok   = 1'b1;
            sym_diff = item.symbol - 8'h18;
        end
        sym_value = sym_diff[4:0];
    end

    assign pad_run_new = pad_run_reg + {3'd0, is_pad};
    assign full_group  = {group_bits_reg, (is_pad ? 5'd0 : sym_value)};

    always_comb
    begin
        pad_ok    = 1'b1;
        nbytes    = 3'd0;
        tail_mask = '0;
        unique case (pad_run_new)
            4'd0:
            begin
                nbytes = 3'd5;
            end
            4'd1:
            begin
                nbytes    = 3'd4;
                tail_mask = 40'h00_0000_00FF;
            end
            4'd3:
            begin
                nbytes    = 3'd3;
                tail_mask = 40'h00_0000_FFFF;
            end
            4'd4:
            begin
                nbytes    = 3'd2;
                tail_mask = 40'h00_00FF_FFFF;
            end
            4'd6:
            begin
                nbytes    = 3'd1;
                tail_mask = 40'h00_FFFF_FFFF;
            end
            default:
            begin
                pad_ok = 1'b0;
            end
        endcase
    end

    assign tail_ok   = ((full_group & tail_mask) == '0);
    assign total_sum = {1'b0, total_reg} + (COUNT_BITS+1)'(nbytes);
    assign total_sat = total_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : total_sum[COUNT_BITS-1:0];

    // status count is capped at the field width
    assign total_wide = WIDE'(total_reg);
    assign shown      = (total_wide > WIDE'({FB{1'b1}})) ? {FB{1'b1}} : total_wide[FB-1:0];
    assign end_bad    = error_reg || (group_pos_reg != 3'd0);

    always_comb
    begin
        group_bits_next  = group_bits_reg;
        group_pos_next   = group_pos_reg;
        pad_run_next     = pad_run_reg;
        error_next       = error_reg;
        padded_done_next = padded_done_reg;
        total_next       = total_reg;
        push             = 1'b0;
        push_job         = '0;

        if (accept)
        begin
            priority if (item.kind == sb32_pkg::KIND_END)
            begin
                push                  = 1'b1;
                push_job.is_status    = 1'b1;
                push_job.decode_error = end_bad;
                push_job.byte_count   = end_bad ? '0 : shown;
                group_pos_next        = 3'd0;
                pad_run_next          = 4'd0;
                error_next            = 1'b0;
                padded_done_next      = 1'b0;
                total_next            = '0;
            end
            else if (error_reg)
            begin
                error_next = 1'b1;
            end
            else if (padded_done_reg)
            begin
                error_next = 1'b1;
            end
            else if (!is_pad && (pad_run_reg != 4'd0 || !sym_ok))
            begin
                error_next = 1'b1;
            end
            else
            begin
                group_bits_next = full_group[KEEP-1:0];
                group_pos_next  = group_pos_reg + 3'd1;
                pad_run_next    = pad_run_new;
                if (group_pos_reg == 3'd7)
                begin
                    pad_run_next = 4'd0;
                    if (pad_ok && tail_ok)
                    begin
                        push             = 1'b1;
                        push_job.group   = full_group;
                        push_job.nbytes  = nbytes;
                        total_next       = total_sat;
                        padded_done_next = (pad_run_new != 4'd0);
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_pos_reg   <= 3'd0;
            pad_run_reg     <= 4'd0;
            error_reg       <= 1'b0;
            padded_done_reg <= 1'b0;
            total_reg       <= '0;
        end
        else
        begin
            group_pos_reg   <= group_pos_next;
            pad_run_reg     <= pad_run_next;
            error_reg       <= error_next;
            padded_done_reg <= padded_done_next;
            total_reg       <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        group_bits_reg <= group_bits_next;
    end

endmodule

>>> rtl/core/sb32_queue.sv
// small job queue between the input side and the output side
module sb32_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  sb32_pkg::queue_wr_t wr,
    input  sb32_pkg::job_t     wr_job,
    output logic               full,
    input  logic               pop,
    output sb32_pkg::job_t     head,
    output logic               empty
);

    localparam int PB = sb32_pkg::QUEUE_PTR_BITS;

    sb32_pkg::job_t entry_reg [sb32_pkg::QUEUE_DEPTH];

    logic [PB-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PB:0]   count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == (PB+1)'(sb32_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = wr.push && !wr.full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PB'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PB'(1) : rd_ptr_reg;
        count_next  = count_reg + (PB+1)'(do_push) - (PB+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> rtl/core/sb32_back.sv
// output side: unpacks jobs into byte and status transactions
module sb32_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sb32_pkg::job_t    head,
    input  logic              empty,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output sb32_pkg::result_t result
);

    logic              busy_reg, busy_next;
    sb32_pkg::job_t    job_reg, job_next;
    logic [2:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    sb32_pkg::result_t out_reg, out_next;

    sb32_pkg::job_t    src;
    logic [2:0]        idx;
    logic              slot_free;
    logic              emit;
    logic              last;
    logic [7:0]        sel_byte;
    sb32_pkg::result_t res;

    assign slot_free = !out_valid_reg || result_ready;
    assign src       = busy_reg ? job_reg : head;
    assign idx       = busy_reg ? idx_reg : 3'd0;
    assign emit      = slot_free && (busy_reg || !empty);
    assign last      = src.is_status || (idx == src.nbytes - 3'd1);
    assign pop       = emit && !busy_reg;

    // most significant byte first
    always_comb
    begin
        unique case (idx)
            3'd0:    sel_byte = src.group[39:32];
            3'd1:    sel_byte = src.group[31:24];
            3'd2:    sel_byte = src.group[23:16];
            3'd3:    sel_byte = src.group[15:8];
            3'd4:    sel_byte = src.group[7:0];
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        res = '0;
        if (src.is_status)
        begin
            res.result_kind  = sb32_pkg::KIND_END;
            res.final_of_run = 1'b1;
            res.decode_error = src.decode_error;
            res.byte_count   = src.byte_count;
        end
        else
        begin
            res.result_kind  = sb32_pkg::KIND_CHAR;
            res.data_byte    = sel_byte;
            res.final_of_run = last;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        busy_next      = busy_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
            busy_next      = !last;
            job_next       = src;
            idx_next       = idx + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> rtl/core/strict_base32_decoder.sv
// top level of the strict padded base32 decoder
//
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      sb32_pkg::item_t (kind, symbol)
// result    out        result_valid / result_ready  sb32_pkg::result_t
//
// one item transaction is taken per cycle whenever the job queue has room
// a completed group yields 1 to 5 byte transactions at one per cycle while result_ready
//   is high, an end item yields one status transaction; each job passes through the job
//   queue and then the registered output stage of the back end before it appears
// the output rate of one result per cycle out of the back end, while result_ready is high,
//   sets throughput: eight characters yield at most five byte results
// rst_n clears all message state and empties the queue; no clearing pass
// result stalls fill the four-entry job queue, then item_ready drops
module strict_base32_decoder #(
    parameter int COUNT_BITS = sb32_pkg::COUNT_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sb32_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output sb32_pkg::result_t result
);

    // front to queue
    sb32_pkg::queue_wr_t wr;
    sb32_pkg::job_t      push_job;
    logic                push;
    logic                queue_full;

    // queue to back
    sb32_pkg::job_t      head;
    logic                empty;
    logic                pop;

    assign wr.push = push;
    assign wr.full = queue_full;

    // symbol checks, group assembly, byte total
    sb32_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // decouples character intake from byte output
    sb32_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .wr_job (push_job),
        .full   (queue_full),
        .pop    (pop),
        .head   (head),
        .empty  (empty)
    );

    // unpacks each job into registered output transactions
    sb32_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> test/tb.sv
// testbench for the strict padded base32 decoder
`timescale 1ns / 1ps

module tb;

    localparam int FB = sb32_pkg::FIELD_BITS;

    // value marking a byte outside the base32 alphabet
    localparam int NOT_B32 = 32;

    // ways a random message can be spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_BYTE,
        FLAW_TRUNCATE,
        FLAW_EXTRA_TAIL,
        FLAW_LOOSE_TAIL,
        FLAW_PAD_COUNT,
        FLAW_EARLY_PAD
    } flaw_t;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    sb32_pkg::item_t   item;
    logic              result_valid;
    logic              result_ready;
    sb32_pkg::result_t result;

    // decoder state mirrored by the predictor
    logic [sb32_pkg::GROUP_BITS-1:0] grp_bits;
    int                              grp_pos;
    int                              pad_run;
    bit                              err_seen;
    bit                              padded_done;
    logic [FB-1:0]                   bytes_total;

    // results still owed by the decoder, oldest first
    sb32_pkg::result_t decoded_q[$];

    // run bookkeeping
    int  mismatches;
    int  items_sent;
    int  results_checked;
    int  messages;
    bit  steady;

    strict_base32_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous ceiling on run length
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // 5-bit value of a character, or NOT_B32 for anything outside the alphabet
    function automatic int b32_value(logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
            return int'(ch) - int'("A");
        if (ch >= "2" && ch <= "7")
            return int'(ch) - int'("2") + 26;
        return NOT_B32;
    endfunction

    // alphabet character for a 5-bit value
    function automatic logic [7:0] b32_char(int v);
        if (v < 26)
            return 8'("A" + v);
        return 8'("2" + v - 26);
    endfunction

    function automatic void clear_group();
        grp_bits = '0;
        grp_pos  = 0;
        pad_run  = 0;
    endfunction

    // advance the mirrored decoder by one accepted item and queue what it emits
    task automatic decode_symbol(input logic kind, input logic [7:0] ch);
        sb32_pkg::result_t r;
        bit                bad;
        int                v;
        int                nbytes;
        int                pads;
        int                unused;
        logic [39:0]       g;
        r = '0;
        // end of message: one status transaction, then back to reset state
        if (kind == sb32_pkg::KIND_END)
        begin
            bad            = err_seen || grp_pos != 0;
            r.result_kind  = sb32_pkg::KIND_END;
            r.final_of_run = 1'b1;
            r.decode_error = bad;
            r.byte_count   = bad ? '0 : bytes_total;
            decoded_q.push_back(r);
            clear_group();
            err_seen    = 1'b0;
            padded_done = 1'b0;
            bytes_total = '0;
            return;
        end
        // characters after an error are dropped silently
        if (err_seen)
            return;
        // anything after a padded group is malformed
        if (padded_done)
        begin
            err_seen = 1'b1;
            return;
        end
        if (ch == sb32_pkg::PAD_SYMBOL)
            pad_run++;
        else
        begin
            v = b32_value(ch);
            // data after padding, or a byte outside the alphabet
            if (pad_run != 0 || v == NOT_B32)
            begin
                err_seen = 1'b1;
                return;
            end
            grp_bits |= 40'(v) << (5 * (7 - grp_pos));
        end
        grp_pos++;
        if (grp_pos < 8)
            return;
        // group complete: padding decides how many bytes it holds
        case (pad_run)
            0:       nbytes = 5;
            1:       nbytes = 4;
            3:       nbytes = 3;
            4:       nbytes = 2;
            6:       nbytes = 1;
            default: nbytes = 0;
        endcase
        g    = grp_bits;
        pads = pad_run;
        clear_group();
        if (nbytes == 0)
        begin
            err_seen = 1'b1;
            return;
        end
        // leftover bits below the last byte must be zero
        unused = 40 - 8 * nbytes;
        if (unused > 0 && (g & ((40'd1 << unused) - 40'd1)) != '0)
        begin
            err_seen = 1'b1;
            return;
        end
        for (int j = 0; j < nbytes; j++)
        begin
            r              = '0;
            r.result_kind  = sb32_pkg::KIND_CHAR;
            r.data_byte    = g[39 - 8 * j -: 8];
            r.final_of_run = (j == nbytes - 1);
            decoded_q.push_back(r);
        end
        // saturating byte total
        if (bytes_total > {FB{1'b1}} - FB'(nbytes))
            bytes_total = '1;
        else
            bytes_total += FB'(nbytes);
        if (pads != 0)
            padded_done = 1'b1;
    endtask

    // drive one item transaction; returns at the edge where it is taken
    task automatic send_item(input logic kind, input logic [7:0] ch);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= {kind, ch};
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        decode_symbol(kind, ch);
    endtask

    // a whole message given as text, closed by an end item
    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_item(sb32_pkg::KIND_CHAR, text[i]);
        send_item(sb32_pkg::KIND_END, 8'($urandom_range(0, 255)));
        messages++;
    endtask

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // single padded group holding one byte
    task automatic test_padded_group();
        send_text("MY======");
    endtask

    // extreme byte values, both outside the alphabet; the second arrives after the error
    task automatic test_bad_symbols();
        send_item(sb32_pkg::KIND_CHAR, 8'h00);
        send_item(sb32_pkg::KIND_CHAR, 8'hFF);
        send_item(sb32_pkg::KIND_END, 8'hFF);
        messages++;
    endtask

    // data symbol following a pad inside one group
    task automatic test_pad_then_data();
        send_text("M=A");
    endtask

    // message ends in the middle of a group
    task automatic test_partial_group();
        send_text("A");
    endtask

    // end item with nothing before it
    task automatic test_empty_message();
        send_item(sb32_pkg::KIND_END, 8'h00);
        messages++;
    endtask

    // full five-byte group, then hold the sender until the decoder has drained
    task automatic test_drain_pause();
        string text;
        text = "MZXW6YTB";
        for (int i = 0; i < text.len(); i++)
            send_item(sb32_pkg::KIND_CHAR, text[i]);
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_q.size() != 0);
        send_item(sb32_pkg::KIND_END, 8'h5A);
        messages++;
    endtask

    // mostly well-formed messages with random content, some spoiled on purpose
    task automatic test_random_messages();
        int          good_pads[5] = '{0, 1, 3, 4, 6};
        int          bad_pads[4]  = '{2, 5, 7, 8};
        logic [7:0]  chars[$];
        flaw_t       flaw;
        int          ngroups;
        int          pads;
        int          ndata;
        int          v;
        int          lost;
        int          idx;
        while (items_sent < 350)
        begin
            chars.delete();
            steady = ($urandom_range(0, 4) == 0);
            flaw   = ($urandom_range(0, 9) < 3) ? flaw_t'($urandom_range(1, 6)) : FLAW_NONE;
            ngroups = $urandom_range(0, 3);
            if (ngroups == 0 && flaw != FLAW_NONE)
                ngroups = 1;
            for (int g = 0; g < ngroups; g++)
            begin
                pads = 0;
                if (g == ngroups - 1)
                begin
                    if (flaw == FLAW_PAD_COUNT)
                        pads = bad_pads[$urandom_range(0, 3)];
                    else if (flaw == FLAW_LOOSE_TAIL)
                        pads = good_pads[$urandom_range(1, 4)];
                    else
                        pads = good_pads[$urandom_range(0, 4)];
                end
                ndata = 8 - pads;
                // bits of the last symbol that fall below the last whole byte
                case (pads)
                    1:       lost = 3;
                    3:       lost = 1;
                    4:       lost = 4;
                    6:       lost = 2;
                    default: lost = 0;
                endcase
                for (int i = 0; i < ndata; i++)
                begin
                    v = $urandom_range(0, 31);
                    if (i == ndata - 1 && flaw != FLAW_LOOSE_TAIL)
                        v = (v >> lost) << lost;
                    chars.push_back(b32_char(v));
                end
                repeat (pads) chars.push_back(sb32_pkg::PAD_SYMBOL);
            end
            idx = 0;
            if (chars.size() > 0)
                idx = $urandom_range(0, chars.size() - 1);
            case (flaw)
                FLAW_BAD_BYTE:   chars[idx] = 8'($urandom_range(0, 255));
                FLAW_TRUNCATE:   chars = chars[0:chars.size() - 2];
                FLAW_EARLY_PAD:  chars[idx] = sb32_pkg::PAD_SYMBOL;
                FLAW_EXTRA_TAIL:
                    repeat ($urandom_range(1, 8)) chars.push_back(b32_char($urandom_range(0, 31)));
                default: ;
            endcase
            foreach (chars[i])
                send_item(sb32_pkg::KIND_CHAR, chars[i]);
            send_item(sb32_pkg::KIND_END, 8'($urandom_range(0, 255)));
            messages++;
        end
        steady = 1'b0;
    endtask

    // result side: random back-pressure, each result transaction checked in order
    initial
    begin : result_side
        int                stall;
        sb32_pkg::result_t want;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result transaction %p", result);
                mismatches++;
            end
            else
            begin
                want = decoded_q.pop_front();
                compare_field("result_kind", want.result_kind, result.result_kind);
                compare_field("data_byte", want.data_byte, result.data_byte);
                compare_field("final_of_run", want.final_of_run, result.final_of_run);
                compare_field("decode_error", want.decode_error, result.decode_error);
                compare_field("byte_count", want.byte_count, result.byte_count);
                results_checked++;
            end
        end
    end

    // stimulus: reset, directed tests, random messages, drain
    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        mismatches      = 0;
        items_sent      = 0;
        results_checked = 0;
        messages        = 0;
        steady          = 1'b0;
        clear_group();
        err_seen    = 1'b0;
        padded_done = 1'b0;
        bytes_total = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_padded_group();
        test_bad_symbols();
        test_pad_then_data();
        test_partial_group();
        test_empty_message();
        test_drain_pause();
        test_random_messages();

        // last item taken; let the decoder empty out
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_q.size() != 0);
        repeat (10) @(posedge clk);

        $display("run covered %0d item transactions in %0d messages, %0d results compared",
                 items_sent, messages, results_checked);
        $display("mix: padded and full groups, bad bytes, bad padding, loose tails, cut groups");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
